>>> hdl/efuse_pkg.sv
// ----------------------------------------------------------------------------
// efuse_pkg
// Shared constants, types and helpers for the fuse controller register block.
// ----------------------------------------------------------------------------
package efuse_pkg;

  // Default number of 32-bit fuse words.
  localparam int FUSE_WORDS_DEF = 8;

  // Item command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [7:0] REG_CTRL   = 8'h00;
  localparam logic [7:0] REG_STATUS = 8'h08;
  localparam logic [7:0] REG_DATA0  = 8'h10;
  localparam logic [7:0] REG_TIMING = 8'h40;

  // Operation modes held in the control register's low bits.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_SENSE = 2'd1;
  localparam logic [1:0] MODE_PROG  = 2'd2;
  localparam logic [1:0] MODE_MASK  = 2'd3;

  // Status register fields.
  localparam logic [31:0] STATUS_BUSY = 32'h8000_0000;
  localparam logic [31:0] STATUS_ERR  = 32'h0000_4c00;

  // Configuration register indexes and reset values.
  localparam logic CFG_SENSE_TICKS   = 1'b0;
  localparam logic CFG_PROGRAM_TICKS = 1'b1;
  localparam logic [15:0] SENSE_TICKS_RST   = 16'd4;
  localparam logic [15:0] PROGRAM_TICKS_RST = 16'd16;

  // Result of one item as computed by the core.
  typedef struct packed {
    logic [31:0] rdata;
    logic        busy;
  } efuse_res_t;

  // Error bits 0, 1, 2 live at status bits 10, 11, 14.
  function automatic logic [31:0] err_to_status(input logic [2:0] e);
    logic [31:0] s;
    s     = '0;
    s[10] = e[0];
    s[11] = e[1];
    s[14] = e[2];
    return s;
  endfunction

  function automatic logic [2:0] status_to_err(input logic [31:0] s);
    return {s[14], s[11], s[10]};
  endfunction

endpackage

>>> hdl/efuse_core.sv
// ----------------------------------------------------------------------------
// efuse_core
// Register map state, fuse bank and operation timer. Applies one registered
// item per cycle and produces its result combinationally.
// ----------------------------------------------------------------------------
module efuse_core #(
  parameter int FUSE_WORDS = efuse_pkg::FUSE_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  logic [1:0]            item_cmd,
  input  logic [7:0]            item_addr,
  input  logic [31:0]           item_wdata,
  input  logic [2:0]            item_fault,
  input  logic                  cfg_we,
  input  logic                  cfg_idx,
  input  logic [15:0]           cfg_wdata,
  output efuse_pkg::efuse_res_t res
);

  localparam int IDX_W = (FUSE_WORDS > 1) ? $clog2(FUSE_WORDS) : 1;

  logic [31:0] fuse_r   [FUSE_WORDS];
  logic [31:0] fuse_nxt [FUSE_WORDS];
  logic [31:0] data_r   [FUSE_WORDS];
  logic [31:0] data_nxt [FUSE_WORDS];
  logic [31:2] ctrl_r, ctrl_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] timing_r, timing_nxt;
  logic [15:0] sense_ticks_r, program_ticks_r;

  logic [7:0]       data_off;
  logic             data_hit;
  logic [IDX_W-1:0] data_idx;
  logic             is_read, is_write, is_tick;
  logic             wr_ok, done;
  logic [15:0]      count_dec;

  // Data word decode: aligned offsets from the first data word.
  assign data_off = item_addr - efuse_pkg::REG_DATA0;
  assign data_hit = (item_addr >= efuse_pkg::REG_DATA0) && (item_addr[1:0] == 2'b00)
                    && (data_off[7:2] < 6'(FUSE_WORDS));
  assign data_idx = data_off[IDX_W+1:2];

  assign is_read  = item_valid && (item_cmd == efuse_pkg::CMD_READ);
  assign is_write = item_valid && (item_cmd == efuse_pkg::CMD_WRITE);
  assign is_tick  = item_valid && (item_cmd == efuse_pkg::CMD_TICK);

  // Writes are dropped while an operation runs.
  assign wr_ok     = is_write && (mode_r == efuse_pkg::MODE_IDLE);
  assign count_dec = count_r - 16'd1;
  assign done      = is_tick && (mode_r != efuse_pkg::MODE_IDLE) && (count_dec == 16'd0);

  // Next state for one item.
  always_comb begin
    ctrl_nxt   = ctrl_r;
    err_nxt    = err_r;
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    timing_nxt = timing_r;
    for (int i = 0; i < FUSE_WORDS; i++) begin
      fuse_nxt[i] = fuse_r[i];
      data_nxt[i] = data_r[i];
    end

    if (wr_ok) begin
      if (item_addr == efuse_pkg::REG_CTRL) begin
        ctrl_nxt = item_wdata[31:2];
        if (item_wdata[1:0] == efuse_pkg::MODE_SENSE) begin
          mode_nxt  = efuse_pkg::MODE_SENSE;
          count_nxt = (sense_ticks_r != 16'd0) ? sense_ticks_r : 16'd1;
        end else if (item_wdata[1:0] == efuse_pkg::MODE_PROG) begin
          mode_nxt  = efuse_pkg::MODE_PROG;
          count_nxt = (program_ticks_r != 16'd0) ? program_ticks_r : 16'd1;
        end
      end else if (item_addr == efuse_pkg::REG_STATUS) begin
        err_nxt = err_r & ~efuse_pkg::status_to_err(item_wdata);
      end else if (item_addr == efuse_pkg::REG_TIMING) begin
        timing_nxt = item_wdata;
      end else if (data_hit) begin
        data_nxt[data_idx] = item_wdata;
      end
    end

    // Ticks count the running operation down; the last one completes it.
    if (is_tick && (mode_r != efuse_pkg::MODE_IDLE)) begin
      count_nxt = count_dec;
      if (done) begin
        mode_nxt = efuse_pkg::MODE_IDLE;
        if (mode_r == efuse_pkg::MODE_SENSE) begin
          for (int i = 0; i < FUSE_WORDS; i++) begin
            data_nxt[i] = fuse_r[i];
          end
        end else if (item_fault != 3'd0) begin
          err_nxt = err_r | item_fault;
        end else begin
          for (int i = 0; i < FUSE_WORDS; i++) begin
            fuse_nxt[i] = fuse_r[i] | data_r[i];
          end
        end
      end
    end
  end

  // Read mux and result for the current item.
  always_comb begin
    res.rdata = '0;
    if (is_read) begin
      if (item_addr == efuse_pkg::REG_CTRL) begin
        res.rdata = {ctrl_r, mode_r};
      end else if (item_addr == efuse_pkg::REG_STATUS) begin
        res.rdata = ((mode_r != efuse_pkg::MODE_IDLE) ? efuse_pkg::STATUS_BUSY : 32'd0)
                    | efuse_pkg::err_to_status(err_r);
      end else if (item_addr == efuse_pkg::REG_TIMING) begin
        res.rdata = timing_r;
      end else if (data_hit) begin
        res.rdata = data_r[data_idx];
      end
    end
    res.busy = (mode_nxt != efuse_pkg::MODE_IDLE);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      err_r    <= '0;
      mode_r   <= efuse_pkg::MODE_IDLE;
      count_r  <= '0;
      timing_r <= '0;
      for (int i = 0; i < FUSE_WORDS; i++) begin
        fuse_r[i] <= '0;
        data_r[i] <= '0;
      end
    end else begin
      ctrl_r   <= ctrl_nxt;
      err_r    <= err_nxt;
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      timing_r <= timing_nxt;
      for (int i = 0; i < FUSE_WORDS; i++) begin
        fuse_r[i] <= fuse_nxt[i];
        data_r[i] <= data_nxt[i];
      end
    end
  end

  // Timing configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sense_ticks_r   <= efuse_pkg::SENSE_TICKS_RST;
      program_ticks_r <= efuse_pkg::PROGRAM_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_idx == efuse_pkg::CFG_SENSE_TICKS) begin
        sense_ticks_r <= cfg_wdata;
      end else begin
        program_ticks_r <= cfg_wdata;
      end
    end
  end

  // The mode field never holds the reserved encoding.
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != efuse_pkg::MODE_MASK)
    else $error("reserved operation mode");

  // A running operation always has ticks left.
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != efuse_pkg::MODE_IDLE) |-> (count_r != 16'd0))
    else $error("operation running with zero countdown");

  // A bus write while busy leaves control and timing untouched.
  a_busy_write: assert property (@(posedge clk) disable iff (!rst_n)
    (is_write && (mode_r != efuse_pkg::MODE_IDLE)) |=>
      ($stable(ctrl_r) && $stable(timing_r)))
    else $error("write accepted while busy");

  // Fuses only ever go from 0 to 1.
  for (genvar g = 0; g < FUSE_WORDS; g++) begin : g_fuse_chk
    a_fuse_mono: assert property (@(posedge clk) disable iff (!rst_n)
      $past(rst_n) |-> (($past(fuse_r[g]) & ~fuse_r[g]) == 32'd0))
      else $error("fuse bit cleared");
  end

endmodule

>>> hdl/efuse_otp_controller.sv
// ----------------------------------------------------------------------------
// efuse_otp_controller
// One-time-programmable fuse controller with a small register map.
// ----------------------------------------------------------------------------
// The result of an item is strobed on out_valid.
// Throughput: one item per cycle; busy stays low, so start is never refused.
// Each item passes an input register, then the register map logic, then the
// result register. The receiver cannot stall.
// Reset (rst_n low, synchronous) blanks the fuses, clears the register map
// and valid flags, and restores the sense and program tick counts to 4 and 16.
module efuse_otp_controller #(
  parameter int FUSE_WORDS = efuse_pkg::FUSE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte_addr,
  input  logic [31:0] in_wdata,
  input  logic [2:0]  in_fault,
  output logic        out_valid,
  output logic [31:0] out_rdata,
  output logic        out_busy_res,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic                 in_valid_r;
  logic [1:0]           cmd_r;
  logic [7:0]           addr_r;
  logic [31:0]          wdata_r;
  logic [2:0]           fault_r;
  efuse_pkg::efuse_res_t res;
  logic                 out_valid_r;
  logic [31:0]          rdata_r;
  logic                 busy_res_r;

  assign busy = 1'b0;

  // Input register: capture one item per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= in_cmd;
    addr_r  <= in_byte_addr;
    wdata_r <= in_wdata;
    fault_r <= in_fault;
  end

  efuse_core #(
    .FUSE_WORDS(FUSE_WORDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item_cmd   (cmd_r),
    .item_addr  (addr_r),
    .item_wdata (wdata_r),
    .item_fault (fault_r),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .res        (res)
  );

  // Result register: one-cycle strobe per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r    <= res.rdata;
    busy_res_r <= res.busy;
  end

  assign out_valid    = out_valid_r;
  assign out_rdata    = rdata_r;
  assign out_busy_res = busy_res_r;

endmodule

>>> sim/efuse_otp_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efuse_otp_controller_tb
// Drives bus reads, bus writes and ticks into the fuse controller and checks
// every result against an in-bench model of the register map and fuse bank or
// a hand-written value. A directed table comes first, then random traffic that
// is mostly complete sense and program runs, under several tick settings.
// ----------------------------------------------------------------------------
module efuse_otp_controller_tb;
  import efuse_pkg::*;

  localparam int NWORDS = FUSE_WORDS_DEF;
  // Command code with no defined action.
  localparam logic [1:0] CMD_NONE = 2'd3;
  // About 1500 items, the slowest phases idling more than half the time, run
  // well inside the limit, which is many times what they need.
  localparam int CYCLE_LIMIT = 40000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] wdata;
    logic [2:0]  fault;
  } fuse_item_t;

  typedef struct packed {
    fuse_item_t item;
    logic       typed;
    efuse_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_byte_addr = '0;
  logic [31:0] in_wdata = '0;
  logic [2:0]  in_fault = '0;
  logic        out_valid;
  logic [31:0] out_rdata;
  logic        out_busy_res;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Model state, kept in step with every accepted item.
  logic [31:0] fuse_bank [NWORDS] = '{default: '0};
  logic [31:0] data_word [NWORDS] = '{default: '0};
  logic [31:0] ctrl_hi = '0;
  logic [2:0]  err_flags = '0;
  logic [1:0]  run_mode = MODE_IDLE;
  logic [15:0] ticks_left = '0;
  logic [31:0] timing_word = '0;
  logic [15:0] sense_len = SENSE_TICKS_RST;
  logic [15:0] prog_len = PROGRAM_TICKS_RST;

  efuse_res_t expected_q [$];
  efuse_res_t want;
  int         err_cnt = 0;
  int         item_cnt = 0;
  int         cycle_cnt = 0;
  int         idle_pct = 0;

  // Directed items. Rows with typed set carry a hand-written result; the
  // rest are checked against the model. Runs with sense 0 and program 2.
  dir_row_t dir_tab [27] = '{
    // Reads after reset, unmapped and unaligned reads.
    '{'{CMD_READ,  REG_CTRL,   32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  REG_DATA0,  32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  REG_TIMING, 32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  8'hff,      32'hffff_ffff, 3'd7}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  8'h11,      32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    // A tick while idle and the undefined command do nothing.
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd7}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_NONE,  8'hff,      32'hffff_ffff, 3'd7}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_WRITE, REG_TIMING, 32'hffff_ffff, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  REG_TIMING, 32'h0000_0000, 3'd0}, 1'b1, '{32'hffff_ffff, 1'b0}},
    '{'{CMD_WRITE, REG_DATA0,  32'hffff_ffff, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_WRITE, 8'h2c,      32'ha5a5_a5a5, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    // Unaligned write is dropped; mode 3 starts nothing.
    '{'{CMD_WRITE, 8'h11,      32'h1234_5678, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_WRITE, REG_CTRL,   32'hffff_ffff, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  REG_CTRL,   32'h0000_0000, 3'd0}, 1'b1, '{32'hffff_fffc, 1'b0}},
    // Program with a fault on the completing tick; earlier faults ignored.
    '{'{CMD_WRITE, REG_CTRL,   32'h0000_0002, 3'd0}, 1'b1, '{32'h0000_0000, 1'b1}},
    '{'{CMD_WRITE, REG_DATA0,  32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0000, 1'b1}},
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd5}, 1'b1, '{32'h0000_0000, 1'b1}},
    '{'{CMD_READ,  REG_STATUS, 32'h0000_0000, 3'd0}, 1'b1, '{32'h8000_0000, 1'b1}},
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd3}, 1'b1, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  REG_STATUS, 32'h0000_0000, 3'd0}, 1'b1, '{32'h0000_0c00, 1'b0}},
    '{'{CMD_WRITE, REG_STATUS, 32'h0000_0400, 3'd0}, 1'b1, '{32'h0000_0000, 1'b0}},
    // Clean program, then a sense with a zero tick count.
    '{'{CMD_WRITE, REG_CTRL,   32'h0000_0002, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{CMD_WRITE, REG_CTRL,   32'h0000_0001, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{CMD_TICK,  8'h00,      32'h0000_0000, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}},
    '{'{CMD_READ,  8'h2c,      32'h0000_0000, 3'd0}, 1'b0, '{32'h0000_0000, 1'b0}}
  };

  efuse_otp_controller #(
    .FUSE_WORDS(NWORDS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_byte_addr(in_byte_addr),
    .in_wdata    (in_wdata),
    .in_fault    (in_fault),
    .out_valid   (out_valid),
    .out_rdata   (out_rdata),
    .out_busy_res(out_busy_res),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block stops answering.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void flag_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t: mismatch on %0s: expected %08h, got %08h", $realtime, what, exp_v, got_v);
  endfunction

  // Data word slot for a byte offset, or -1 when the offset is not a data word.
  function automatic int word_slot(logic [7:0] a);
    if (a < REG_DATA0 || a[1:0] != 2'b00)
      return -1;
    if (int'((a - REG_DATA0) >> 2) >= NWORDS)
      return -1;
    return int'((a - REG_DATA0) >> 2);
  endfunction

  function automatic logic [31:0] err_status_bits(logic [2:0] e);
    return {17'b0, e[2], 2'b0, e[1], e[0], 10'b0};
  endfunction

  // Applies one accepted item to the model and returns its result.
  function automatic efuse_res_t apply_item(fuse_item_t it);
    efuse_res_t r;
    int         k;
    r.rdata = '0;
    k = word_slot(it.addr);
    case (it.cmd)
      CMD_READ: begin
        if (it.addr == REG_CTRL)
          r.rdata = {ctrl_hi[31:2], run_mode};
        else if (it.addr == REG_STATUS)
          r.rdata = (run_mode != MODE_IDLE ? STATUS_BUSY : 32'h0) | err_status_bits(err_flags);
        else if (it.addr == REG_TIMING)
          r.rdata = timing_word;
        else if (k >= 0)
          r.rdata = data_word[k];
      end
      CMD_WRITE: begin
        // Every write is dropped while an operation runs.
        if (run_mode == MODE_IDLE) begin
          if (it.addr == REG_CTRL) begin
            ctrl_hi = {it.wdata[31:2], 2'b00};
            if (it.wdata[1:0] == MODE_SENSE) begin
              run_mode = MODE_SENSE;
              ticks_left = (sense_len != 0) ? sense_len : 16'd1;
            end else if (it.wdata[1:0] == MODE_PROG) begin
              run_mode = MODE_PROG;
              ticks_left = (prog_len != 0) ? prog_len : 16'd1;
            end
          end else if (it.addr == REG_STATUS) begin
            err_flags &= ~{it.wdata[14], it.wdata[11], it.wdata[10]};
          end else if (it.addr == REG_TIMING) begin
            timing_word = it.wdata;
          end else if (k >= 0) begin
            data_word[k] = it.wdata;
          end
        end
      end
      CMD_TICK: begin
        if (run_mode != MODE_IDLE) begin
          ticks_left = ticks_left - 16'd1;
          if (ticks_left == 0) begin
            if (run_mode == MODE_SENSE) begin
              for (int i = 0; i < NWORDS; i++)
                data_word[i] = fuse_bank[i];
            end else if (it.fault != 0) begin
              err_flags |= it.fault;
            end else begin
              for (int i = 0; i < NWORDS; i++)
                fuse_bank[i] |= data_word[i];
            end
            run_mode = MODE_IDLE;
          end
        end
      end
      default: ;
    endcase
    r.busy = (run_mode != MODE_IDLE);
    return r;
  endfunction

  // Each strobed result is matched against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("result with no item pending", 32'h0, out_rdata);
      end else begin
        want = expected_q.pop_front();
        if (out_rdata !== want.rdata)
          flag_mismatch("rdata", want.rdata, out_rdata);
        if (out_busy_res !== want.busy)
          flag_mismatch("busy_res", {31'b0, want.busy}, {31'b0, out_busy_res});
      end
    end
  end

  function automatic fuse_item_t make_item(logic [1:0] c, logic [7:0] a, logic [31:0] w,
                                           logic [2:0] f);
    fuse_item_t it;
    it.cmd = c;
    it.addr = a;
    it.wdata = w;
    it.fault = f;
    return it;
  endfunction

  function automatic logic [7:0] word_addr(int i);
    return REG_DATA0 + 8'(i * 4);
  endfunction

  // Mostly sparse words, so the fuse bank fills up slowly over the run.
  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 9) == 0)
      return $urandom;
    return $urandom & $urandom & $urandom & $urandom;
  endfunction

  function automatic logic [7:0] rand_addr();
    case ($urandom_range(0, 5))
      0: return REG_CTRL;
      1: return REG_STATUS;
      2: return REG_TIMING;
      3, 4: return word_addr($urandom_range(0, NWORDS - 1));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] tick_fault();
    if ($urandom_range(0, 3) == 0)
      return 3'($urandom_range(1, 7));
    return 3'd0;
  endfunction

  // Presents one item, waits for it to be taken and records its result.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_item(fuse_item_t it, logic typed, efuse_res_t typed_res);
    efuse_res_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= it.cmd;
    in_byte_addr <= it.addr;
    in_wdata <= it.wdata;
    in_fault <= it.fault;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    r = apply_item(it);
    expected_q.push_back(typed ? typed_res : r);
    item_cnt++;
  endtask

  // Tick counts change only once every result has come back.
  task automatic set_ticks(logic [15:0] s, logic [15:0] p);
    start <= 1'b0;
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SENSE_TICKS;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_idx <= CFG_PROGRAM_TICKS;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    sense_len = s;
    prog_len = p;
  endtask

  // Starts an operation and ticks it to completion, mixing in other accesses.
  task automatic run_op(logic [1:0] mode, int mix_pct);
    logic [31:0] w;
    w = $urandom;
    send_item(make_item(CMD_WRITE, REG_CTRL, {w[31:2], mode}, 3'($urandom)), 1'b0, '0);
    while (run_mode != MODE_IDLE) begin
      if ($urandom_range(0, 99) < mix_pct)
        send_item(make_item($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, rand_addr(),
                            rand_word(), 3'($urandom)), 1'b0, '0);
      else
        send_item(make_item(CMD_TICK, 8'($urandom), $urandom, tick_fault()), 1'b0, '0);
    end
  endtask

  task automatic read_all_words();
    for (int i = 0; i < NWORDS; i++)
      send_item(make_item(CMD_READ, word_addr(i), $urandom, 3'($urandom)), 1'b0, '0);
  endtask

  // One random sequence of items.
  task automatic run_scenario();
    int          pick;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    w = $urandom;
    if (pick < 25) begin
      // Load data words ahead of a program.
      repeat ($urandom_range(1, 4))
        send_item(make_item(CMD_WRITE, word_addr($urandom_range(0, NWORDS - 1)), rand_word(),
                            3'($urandom)), 1'b0, '0);
    end else if (pick < 40) begin
      run_op(MODE_PROG, 25);
    end else if (pick < 55) begin
      run_op(MODE_SENSE, 25);
      read_all_words();
    end else if (pick < 65) begin
      // Clear some error flags and look at the status.
      if ($urandom_range(0, 1))
        w = $urandom_range(0, 1) ? STATUS_ERR : 32'hffff_ffff;
      send_item(make_item(CMD_WRITE, REG_STATUS, w, 3'($urandom)), 1'b0, '0);
      send_item(make_item(CMD_READ, REG_STATUS, $urandom, 3'($urandom)), 1'b0, '0);
    end else if (pick < 75) begin
      // Timing storage and control writes that start nothing.
      send_item(make_item(CMD_WRITE, REG_TIMING, $urandom, 3'($urandom)), 1'b0, '0);
      send_item(make_item(CMD_READ, REG_TIMING, $urandom, 3'($urandom)), 1'b0, '0);
      send_item(make_item(CMD_WRITE, REG_CTRL,
                          {w[31:2], $urandom_range(0, 1) ? MODE_IDLE : MODE_MASK},
                          3'($urandom)), 1'b0, '0);
      send_item(make_item(CMD_READ, REG_CTRL, $urandom, 3'($urandom)), 1'b0, '0);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4))
        send_item(make_item(CMD_READ, rand_addr(), $urandom, 3'($urandom)), 1'b0, '0);
    end else begin
      // Unshaped noise over every field.
      repeat ($urandom_range(1, 3))
        send_item(make_item(2'($urandom), 8'($urandom), $urandom, 3'($urandom)), 1'b0, '0);
    end
  endtask

  task automatic run_phase(logic [15:0] s, logic [15:0] p, int idle, int budget);
    int stop_at;
    set_ticks(s, p);
    idle_pct = idle;
    stop_at = item_cnt + budget;
    while (item_cnt < stop_at)
      run_scenario();
    // Noise may have started an operation; finish it before the next setting.
    while (run_mode != MODE_IDLE)
      send_item(make_item(CMD_TICK, 8'($urandom), $urandom, tick_fault()), 1'b0, '0);
  endtask

  initial begin
    int w;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    set_ticks(16'd0, 16'd2);
    idle_pct = 0;
    foreach (dir_tab[i])
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

    // Random traffic under several tick settings and idle rates.
    run_phase(16'd1, 16'd1, 0, 150);
    run_phase(16'd3, 16'd7, 58, 200);
    run_phase(16'd0, 16'd0, 18, 150);
    run_phase(16'd12, 16'd33, 18, 150);

    // One sense and one program with counts that reach the counter's upper byte.
    set_ticks(16'd260, 16'd300);
    idle_pct = 0;
    run_op(MODE_SENSE, 1);
    read_all_words();
    repeat (4)
      send_item(make_item(CMD_WRITE, word_addr($urandom_range(0, NWORDS - 1)), rand_word(),
                          3'($urandom)), 1'b0, '0);
    run_op(MODE_PROG, 1);
    read_all_words();

    run_phase(SENSE_TICKS_RST, PROGRAM_TICKS_RST, 58, 200);

    // Wait for the last results, then a short settle.
    start <= 1'b0;
    for (w = 0; w < DRAIN_CYCLES && expected_q.size() != 0; w++)
      @(posedge clk);
    if (expected_q.size() != 0)
      flag_mismatch("results still pending", 32'(expected_q.size()), 32'h0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
